### rtl/dcirs_pkg.sv
package dcirs_pkg;

  // bus event codes carried by one input item
  typedef enum logic [2:0] {
    OP_ADDR_WRITE  = 3'd0,
    OP_BYTE_RX     = 3'd1,
    OP_STOP        = 3'd2,
    OP_ADDR_READ   = 3'd3,
    OP_BYTE_TX_ACK = 3'd4,
    OP_UPSTREAM    = 3'd5
  } op_e;

  // daisy-chain link state
  typedef enum logic [1:0] {
    CHAIN_INIT   = 2'd0,
    CHAIN_RESET  = 2'd1,
    CHAIN_ACTIVE = 2'd2
  } chain_e;

  // sequencer state of the top level
  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_COMMIT = 1'b1
  } fsm_e;

  // configuration register indexes
  localparam logic [1:0] CFG_MFR_CODE    = 2'd0;
  localparam logic [1:0] CFG_MODULE_TYPE = 2'd1;
  localparam logic [1:0] CFG_MODULE_VER  = 2'd2;

  // daisy register numbers
  localparam logic [2:0] DAISY_ADDRESS  = 3'd0;
  localparam logic [2:0] DAISY_VERSION  = 3'd2;
  localparam logic [2:0] DAISY_TYPE     = 3'd3;
  localparam logic [2:0] DAISY_MOD_VER  = 3'd4;
  localparam logic [2:0] DAISY_MFR_CODE = 3'd5;

  localparam logic [7:0] DEFAULT_ADDRESS = 8'h7F;
  localparam logic [7:0] CHAIN_VERSION   = 8'h04;
  // first register number that maps into the device store
  localparam logic [7:0] DEVICE_BASE     = 8'd8;

  // status of the store walk unit
  typedef struct packed {
    logic busy;
    logic done;
  } walk_status_t;

  function automatic logic [7:0] daisy_value(
    input logic [2:0] reg_num,
    input logic [7:0] own_addr,
    input logic [7:0] mod_type,
    input logic [7:0] mod_ver,
    input logic [7:0] mfr_code
  );
    logic [7:0] val;
    case (reg_num)
      DAISY_ADDRESS:  val = own_addr;
      DAISY_VERSION:  val = CHAIN_VERSION;
      DAISY_TYPE:     val = mod_type;
      DAISY_MOD_VER:  val = mod_ver;
      DAISY_MFR_CODE: val = mfr_code;
      default:        val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

### rtl/dcirs_store.sv
module dcirs_store #(
  parameter int RX_BUFFER_BYTES = 32,
  parameter int DEVICE_REGS     = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 rx_we_i,
  input  logic [$clog2(RX_BUFFER_BYTES)-1:0]   rx_waddr_i,
  input  logic [7:0]                           rx_wdata_i,
  input  logic                                 start_i,
  input  logic [7:0]                           ptr_i,
  input  logic [$clog2(RX_BUFFER_BYTES+1)-1:0] count_i,
  output dcirs_pkg::walk_status_t              status_o
);
  import dcirs_pkg::*;

  localparam int AW = $clog2(RX_BUFFER_BYTES);
  localparam int CW = $clog2(RX_BUFFER_BYTES + 1);
  localparam int SW = (DEVICE_REGS > 1) ? $clog2(DEVICE_REGS) : 1;
  // destination index spans register number minus base plus buffer length
  localparam int DW = 9;

  logic [7:0]    rx_mem [RX_BUFFER_BYTES];
  logic [7:0]    dev_mem [DEVICE_REGS];

  logic          busy_q, busy_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] dst_q, dst_d;
  logic          rd_pend_q, rd_pend_d;
  logic [7:0]    rd_data_q;
  logic          issue;
  logic          done;
  logic          dev_we;

  // receive buffer write port
  always_ff @(posedge clk_i) begin
    if (rx_we_i) begin
      rx_mem[rx_waddr_i] <= rx_wdata_i;
    end
  end

  // receive buffer registered read, one byte per cycle
  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_data_q <= rx_mem[idx_q[AW-1:0]];
    end
  end

  // device store write, bytes past its end are dropped
  always_ff @(posedge clk_i) begin
    if (dev_we) begin
      dev_mem[dst_q[SW-1:0]] <= rd_data_q;
    end
  end

  // walk sequencer: byte 1 up to count-1 of the buffer
  always_comb begin
    busy_d    = busy_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    dst_d     = dst_q;
    issue     = busy_q && (idx_q < cnt_q);
    rd_pend_d = issue;
    dev_we    = rd_pend_q && (dst_q < DW'(DEVICE_REGS));
    done      = busy_q && !issue && !rd_pend_q;
    if (issue) begin
      idx_d = idx_q + CW'(1);
    end
    if (rd_pend_q) begin
      dst_d = dst_q + DW'(1);
    end
    if (done) begin
      busy_d = 1'b0;
    end
    if (start_i) begin
      busy_d    = 1'b1;
      idx_d     = CW'(1);
      cnt_d     = count_i;
      dst_d     = DW'(ptr_i - DEVICE_BASE);
      rd_pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      idx_q     <= '0;
      cnt_q     <= '0;
      dst_q     <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      idx_q     <= idx_d;
      cnt_q     <= cnt_d;
      dst_q     <= dst_d;
      rd_pend_q <= rd_pend_d;
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done;

endmodule

### rtl/daisy_chain_i2c_register_slave_core.sv
// Daisy-chain I2C register slave core. Each input item is one slave bus event or
// upstream pin change and gives exactly one result item. Each item's result is held
// in an output register; the next item is taken as soon as that result is consumed.
// A stop that targets the device registers (register number 8 or more) starts a
// walk over the receive buffer that copies one byte per cycle into the device store
// through a single read port; no item is accepted until the walk ends.
// Configuration writes take effect at once and are never blocked.
module daisy_chain_i2c_register_slave_core #(
  parameter int RX_BUFFER_BYTES = 32,
  parameter int DEVICE_REGS     = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration write port
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  // input items
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] op_i,
  input  logic [7:0] data_byte_i,
  input  logic       upstream_level_i,
  // result items
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       ack_o,
  output logic       tx_valid_o,
  output logic [7:0] tx_data_o,
  output logic       bus_enabled_o,
  output logic [6:0] slave_address_o,
  output logic       pullups_on_o,
  output logic       downstream_released_o,
  output logic       update_valid_o,
  output logic [5:0] update_count_o,
  output logic [1:0] link_state_o
);
  import dcirs_pkg::*;

  localparam int AW = $clog2(RX_BUFFER_BYTES);
  localparam int CW = $clog2(RX_BUFFER_BYTES + 1);

  // configuration registers
  logic [7:0]    mfr_code_q, mod_type_q, mod_ver_q;

  // link and bus state
  fsm_e          state_q, state_d;
  chain_e        chain_q, chain_d;
  logic [7:0]    own_q, own_d;
  logic          bus_on_q, bus_on_d;
  logic          pullups_q, pullups_d;
  logic          dfree_q, dfree_d;
  logic [CW-1:0] count_q, count_d;
  logic [7:0]    ptr_q, ptr_d;
  logic [7:0]    byte1_q, byte1_d;
  logic          read_done_q, read_done_d;

  // result register
  logic          out_valid_q, out_valid_d;
  logic          ack_q, ack_d;
  logic          txv_q, txv_d;
  logic [7:0]    txd_q, txd_d;
  logic          upd_q, upd_d;
  logic [5:0]    cnt_q, cnt_d;

  logic          accept;
  logic          rx_we;
  logic          walk_start;
  logic [7:0]    daisy_byte;
  walk_status_t  walk_st;

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign daisy_byte = (ptr_q < DEVICE_BASE)
                    ? daisy_value(ptr_q[2:0], own_q, mod_type_q, mod_ver_q, mfr_code_q)
                    : 8'h00;

  // receive buffer and device store walk
  dcirs_store #(
    .RX_BUFFER_BYTES(RX_BUFFER_BYTES),
    .DEVICE_REGS    (DEVICE_REGS)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rx_we_i   (rx_we),
    .rx_waddr_i(count_q[AW-1:0]),
    .rx_wdata_i(data_byte_i),
    .start_i   (walk_start),
    .ptr_i     (ptr_q),
    .count_i   (count_q),
    .status_o  (walk_st)
  );

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mfr_code_q <= '0;
      mod_type_q <= '0;
      mod_ver_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MFR_CODE:    mfr_code_q <= cfg_data_i;
        CFG_MODULE_TYPE: mod_type_q <= cfg_data_i;
        CFG_MODULE_VER:  mod_ver_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // event decode, next state and result
  always_comb begin
    state_d     = state_q;
    chain_d     = chain_q;
    own_d       = own_q;
    bus_on_d    = bus_on_q;
    pullups_d   = pullups_q;
    dfree_d     = dfree_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    byte1_d     = byte1_q;
    read_done_d = read_done_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ack_d       = ack_q;
    txv_d       = txv_q;
    txd_d       = txd_q;
    upd_d       = upd_q;
    cnt_d       = cnt_q;
    rx_we       = 1'b0;
    walk_start  = 1'b0;

    // walk finished, show the stop result
    if (state_q == ST_COMMIT && walk_st.done) begin
      out_valid_d = 1'b1;
      state_d     = ST_IDLE;
    end

    if (accept) begin
      ack_d       = 1'b0;
      txv_d       = 1'b0;
      txd_d       = 8'h00;
      upd_d       = 1'b0;
      cnt_d       = '0;
      out_valid_d = 1'b1;
      if (bus_on_q && (op_i <= OP_BYTE_TX_ACK)) begin
        case (op_e'(op_i))
          OP_ADDR_WRITE: begin
            count_d = '0;
            ack_d   = 1'b1;
          end
          OP_BYTE_RX: begin
            if (count_q < CW'(RX_BUFFER_BYTES)) begin
              if (count_q == CW'(0)) begin
                ptr_d = data_byte_i;
              end
              if (count_q == CW'(1)) begin
                byte1_d = data_byte_i;
              end
              rx_we   = 1'b1;
              count_d = count_q + CW'(1);
              ack_d   = 1'b1;
            end
          end
          OP_STOP: begin
            ack_d = 1'b1;
            if (ptr_q >= DEVICE_BASE) begin
              walk_start  = 1'b1;
              state_d     = ST_COMMIT;
              out_valid_d = 1'b0;
              upd_d       = 1'b1;
              cnt_d       = 6'(count_q);
            end else if (ptr_q == 8'h00 && count_q == CW'(2)) begin
              own_d   = byte1_q;
              dfree_d = 1'b1;
            end
          end
          OP_ADDR_READ: begin
            txd_d       = daisy_byte;
            txv_d       = 1'b1;
            read_done_d = 1'b1;
          end
          OP_BYTE_TX_ACK: begin
            txd_d       = read_done_q ? 8'h00 : daisy_byte;
            txv_d       = 1'b1;
            read_done_d = 1'b1;
          end
          default: ;
        endcase
      end else if (op_i == OP_UPSTREAM) begin
        if (!upstream_level_i && chain_q != CHAIN_RESET) begin
          chain_d   = CHAIN_RESET;
          bus_on_d  = 1'b0;
          pullups_d = 1'b0;
          dfree_d   = 1'b0;
          own_d     = DEFAULT_ADDRESS;
        end else if (chain_q == CHAIN_RESET) begin
          chain_d   = CHAIN_ACTIVE;
          pullups_d = 1'b1;
          bus_on_d  = 1'b1;
        end
      end
    end
  end

  // state and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      chain_q     <= CHAIN_INIT;
      own_q       <= DEFAULT_ADDRESS;
      bus_on_q    <= 1'b0;
      pullups_q   <= 1'b0;
      dfree_q     <= 1'b0;
      count_q     <= '0;
      ptr_q       <= '0;
      read_done_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      chain_q     <= chain_d;
      own_q       <= own_d;
      bus_on_q    <= bus_on_d;
      pullups_q   <= pullups_d;
      dfree_q     <= dfree_d;
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      read_done_q <= read_done_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload and second received byte
  always_ff @(posedge clk_i) begin
    byte1_q <= byte1_d;
    ack_q   <= ack_d;
    txv_q   <= txv_d;
    txd_q   <= txd_d;
    upd_q   <= upd_d;
    cnt_q   <= cnt_d;
  end

  assign out_valid_o           = out_valid_q;
  assign ack_o                 = ack_q;
  assign tx_valid_o            = txv_q;
  assign tx_data_o             = txd_q;
  assign update_valid_o        = upd_q;
  assign update_count_o        = cnt_q;
  assign bus_enabled_o         = bus_on_q;
  assign slave_address_o       = own_q[6:0];
  assign pullups_on_o          = pullups_q;
  assign downstream_released_o = dfree_q;
  assign link_state_o          = chain_q;

  // checks
  a_walk_tracks_fsm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMMIT) == walk_st.busy)
    else $error("store walk busy out of step with sequencer");

  a_no_accept_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMMIT) |-> (!in_ready_o && !out_valid_q))
    else $error("item path open during store walk");

  a_bus_needs_pullups: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bus_on_q |-> (pullups_q && chain_q == CHAIN_ACTIVE))
    else $error("bus enabled outside active link");

  a_release_when_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dfree_q |-> (chain_q == CHAIN_ACTIVE))
    else $error("downstream released outside active link");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(RX_BUFFER_BYTES))
    else $error("receive count past buffer size");

endmodule

### tb/sv/dcirs_link_checker.sv
module dcirs_link_checker #(
  parameter int RX_BUFFER_BYTES = 32,
  parameter int DEVICE_REGS     = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration writes
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  // input channel
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [2:0] op_i,
  input  logic [7:0] data_byte_i,
  input  logic       upstream_level_i,
  // result channel
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic       ack_i,
  input  logic       tx_valid_i,
  input  logic [7:0] tx_data_i,
  input  logic       bus_enabled_i,
  input  logic [6:0] slave_address_i,
  input  logic       pullups_on_i,
  input  logic       downstream_released_i,
  input  logic       update_valid_i,
  input  logic [5:0] update_count_i,
  input  logic [1:0] link_state_i,
  // status for the testbench top
  output int         fail_count_o,
  output int         pending_o
);
  import dcirs_pkg::*;

  typedef struct packed {
    logic       ack;
    logic       tx_valid;
    logic [7:0] tx_data;
    logic       bus_enabled;
    logic [6:0] slave_address;
    logic       pullups_on;
    logic       downstream_released;
    logic       update_valid;
    logic [5:0] update_count;
    logic [1:0] link_state;
  } bus_result_t;

  // configuration copy
  logic [7:0] mfr_code;
  logic [7:0] mod_type;
  logic [7:0] mod_ver;

  // predicted slave state
  chain_e     link;
  logic [7:0] own_addr;
  logic       bus_on;
  logic       pullups;
  logic       ds_free;
  logic [7:0] rx_buf [RX_BUFFER_BYTES];
  int         rx_count;
  logic [7:0] reg_ptr;
  logic [7:0] dev_store [DEVICE_REGS];
  logic       byte_sent;

  bus_result_t expected_results[$];
  int          fails;

  // daisy register selected by the latest register number
  function automatic logic [7:0] pointed_value();
    logic [7:0] val;
    val = 8'h00;
    if (reg_ptr < DEVICE_BASE) begin
      case (reg_ptr[2:0])
        DAISY_ADDRESS:  val = own_addr;
        DAISY_VERSION:  val = CHAIN_VERSION;
        DAISY_TYPE:     val = mod_type;
        DAISY_MOD_VER:  val = mod_ver;
        DAISY_MFR_CODE: val = mfr_code;
        default:        val = 8'h00;
      endcase
    end
    return val;
  endfunction

  // advance the slave state by one bus event and return its result
  function automatic bus_result_t predict_bus_event(logic [2:0] op, logic [7:0] rx_byte,
                                                    logic level);
    bus_result_t r;
    int          dst;
    r = '0;
    if (op <= OP_BYTE_TX_ACK && bus_on) begin
      case (op)
        OP_ADDR_WRITE: begin
          rx_count = 0;
          r.ack = 1'b1;
        end
        OP_BYTE_RX: begin
          // bytes past a full buffer are dropped and nacked
          if (rx_count < RX_BUFFER_BYTES) begin
            if (rx_count == 0) reg_ptr = rx_byte;
            rx_buf[rx_count] = rx_byte;
            rx_count++;
            r.ack = 1'b1;
          end
        end
        OP_STOP: begin
          if (reg_ptr >= DEVICE_BASE) begin
            // copy data bytes into the device store, dropping those past its end
            dst = int'(reg_ptr) - int'(DEVICE_BASE);
            for (int k = 1; k < rx_count; k++) begin
              if (dst < DEVICE_REGS) dev_store[dst] = rx_buf[k];
              dst++;
            end
            r.update_valid = 1'b1;
            r.update_count = 6'(rx_count);
          end else if (reg_ptr == {5'd0, DAISY_ADDRESS} && rx_count == 2) begin
            own_addr = rx_buf[1];
            ds_free  = 1'b1;
          end
          r.ack = 1'b1;
        end
        OP_ADDR_READ: begin
          r.tx_data  = pointed_value();
          r.tx_valid = 1'b1;
          byte_sent  = 1'b1;
        end
        default: begin
          // only the first byte after an addressed read carries data
          r.tx_data  = byte_sent ? 8'h00 : pointed_value();
          r.tx_valid = 1'b1;
          byte_sent  = 1'b1;
        end
      endcase
    end else if (op == OP_UPSTREAM) begin
      if (!level && link != CHAIN_RESET) begin
        link     = CHAIN_RESET;
        bus_on   = 1'b0;
        pullups  = 1'b0;
        ds_free  = 1'b0;
        own_addr = DEFAULT_ADDRESS;
      end else if (link == CHAIN_RESET) begin
        link    = CHAIN_ACTIVE;
        pullups = 1'b1;
        bus_on  = 1'b1;
      end
    end
    r.bus_enabled         = bus_on;
    r.slave_address       = own_addr[6:0];
    r.pullups_on          = pullups;
    r.downstream_released = ds_free;
    r.link_state          = link;
    return r;
  endfunction

  task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      fails++;
    end
  endtask

  // watch both channels: compare the oldest expectation first, then predict
  always @(posedge clk_i or negedge rst_ni) begin
    bus_result_t want;
    if (!rst_ni) begin
      mfr_code  = 8'h00;
      mod_type  = 8'h00;
      mod_ver   = 8'h00;
      link      = CHAIN_INIT;
      own_addr  = DEFAULT_ADDRESS;
      bus_on    = 1'b0;
      pullups   = 1'b0;
      ds_free   = 1'b0;
      rx_count  = 0;
      reg_ptr   = 8'h00;
      byte_sent = 1'b0;
      fails     = 0;
      expected_results.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_MFR_CODE:    mfr_code = cfg_data_i;
          CFG_MODULE_TYPE: mod_type = cfg_data_i;
          CFG_MODULE_VER:  mod_ver  = cfg_data_i;
          default:         ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result item, ack %0h tx %0h/%0h addr %0h link %0h",
                   $time, ack_i, tx_valid_i, tx_data_i, slave_address_i, link_state_i);
          fails++;
        end else begin
          want = expected_results.pop_front();
          check_field("ack", want.ack, ack_i);
          check_field("tx_valid", want.tx_valid, tx_valid_i);
          check_field("tx_data", want.tx_data, tx_data_i);
          check_field("bus_enabled", want.bus_enabled, bus_enabled_i);
          check_field("slave_address", want.slave_address, slave_address_i);
          check_field("pullups_on", want.pullups_on, pullups_on_i);
          check_field("downstream_released", want.downstream_released,
                      downstream_released_i);
          check_field("update_valid", want.update_valid, update_valid_i);
          check_field("update_count", want.update_count, update_count_i);
          check_field("link_state", want.link_state, link_state_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_results.push_back(predict_bus_event(op_i, data_byte_i, upstream_level_i));
      end
      fail_count_o <= fails;
      pending_o    <= expected_results.size();
    end
  end

endmodule

### tb/sv/daisy_chain_i2c_register_slave_core_tb.sv
module daisy_chain_i2c_register_slave_core_tb;
  import dcirs_pkg::*;

  // bus events the slave treats as no-ops
  localparam logic [2:0] OP_OTHER_LO = 3'd6;
  localparam logic [2:0] OP_OTHER_HI = 3'd7;

  localparam int TARGET_ITEMS   = 1900;
  localparam int PHASES         = 6;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 2000;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_index_i;
  logic [7:0] cfg_data_i;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [2:0] op_i;
  logic [7:0] data_byte_i;
  logic       upstream_level_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic       ack_o;
  logic       tx_valid_o;
  logic [7:0] tx_data_o;
  logic       bus_enabled_o;
  logic [6:0] slave_address_o;
  logic       pullups_on_o;
  logic       downstream_released_o;
  logic       update_valid_o;
  logic [5:0] update_count_o;
  logic [1:0] link_state_o;

  int fail_count;
  int pending;
  int items_sent;
  int quiet_cycles;
  bit no_idle;

  daisy_chain_i2c_register_slave_core u_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_index_i           (cfg_index_i),
    .cfg_data_i            (cfg_data_i),
    .in_valid_i            (in_valid_i),
    .in_ready_o            (in_ready_o),
    .op_i                  (op_i),
    .data_byte_i           (data_byte_i),
    .upstream_level_i      (upstream_level_i),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .ack_o                 (ack_o),
    .tx_valid_o            (tx_valid_o),
    .tx_data_o             (tx_data_o),
    .bus_enabled_o         (bus_enabled_o),
    .slave_address_o       (slave_address_o),
    .pullups_on_o          (pullups_on_o),
    .downstream_released_o (downstream_released_o),
    .update_valid_o        (update_valid_o),
    .update_count_o        (update_count_o),
    .link_state_o          (link_state_o)
  );

  dcirs_link_checker u_checker (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_index_i           (cfg_index_i),
    .cfg_data_i            (cfg_data_i),
    .in_valid_i            (in_valid_i),
    .in_ready_i            (in_ready_o),
    .op_i                  (op_i),
    .data_byte_i           (data_byte_i),
    .upstream_level_i      (upstream_level_i),
    .out_valid_i           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .ack_i                 (ack_o),
    .tx_valid_i            (tx_valid_o),
    .tx_data_i             (tx_data_o),
    .bus_enabled_i         (bus_enabled_o),
    .slave_address_i       (slave_address_o),
    .pullups_on_i          (pullups_on_o),
    .downstream_released_i (downstream_released_o),
    .update_valid_i        (update_valid_o),
    .update_count_i        (update_count_o),
    .link_state_i          (link_state_o),
    .fail_count_o          (fail_count),
    .pending_o             (pending)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // idle length: mostly none or short, a few long
  function automatic int gap_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side stalls
  initial begin
    int hold;
    hold = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        out_ready_i = 1'b0;
        hold--;
      end else begin
        out_ready_i = 1'b1;
        if ($urandom_range(0, 3) == 0) hold = gap_len();
      end
    end
  end

  // watchdog on cycles without any accepted item or consumed result
  initial quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // offer one item after a random gap and hold it until accepted
  task automatic send_event(input logic [2:0] op, input logic [7:0] rx_byte,
                            input logic level);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i       = 1'b1;
    op_i             = op;
    data_byte_i      = rx_byte;
    upstream_level_i = level;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
  endtask

  // event whose byte and level are don't-care
  task automatic send_op(input logic [2:0] op);
    send_event(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // register writes only once the slave has gone quiet
  task automatic write_settings(input logic [7:0] mfr, input logic [7:0] mtype,
                                input logic [7:0] mver);
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = CFG_MFR_CODE;
    cfg_data_i  = mfr;
    @(negedge clk_i);
    cfg_index_i = CFG_MODULE_TYPE;
    cfg_data_i  = mtype;
    @(negedge clk_i);
    cfg_index_i = CFG_MODULE_VER;
    cfg_data_i  = mver;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic logic [7:0] pick_setting();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one bus transaction: mostly well-formed writes and reads, some noise
  task automatic random_transaction();
    int         kind;
    int         sel;
    int         n;
    logic [7:0] reg_num;
    logic       level;
    kind = $urandom_range(0, 99);
    if (kind < 45) begin
      sel = $urandom_range(0, 9);
      if (sel < 4) reg_num = 8'($urandom_range(0, 7));
      else if (sel < 9) reg_num = 8'($urandom_range(8, 80));
      else reg_num = 8'($urandom_range(81, 255));
      sel = $urandom_range(0, 9);
      if (reg_num == 8'h00 && sel < 5) n = 1;
      else if (sel < 7) n = $urandom_range(0, 4);
      else if (sel < 9) n = $urandom_range(5, 20);
      else n = $urandom_range(28, 40);
      send_op(OP_ADDR_WRITE);
      if ($urandom_range(0, 19) != 0) begin
        send_event(OP_BYTE_RX, reg_num, 1'($urandom_range(0, 1)));
        repeat (n) send_op(OP_BYTE_RX);
      end
      if ($urandom_range(0, 9) != 0) send_op(OP_STOP);
    end else if (kind < 75) begin
      send_op(OP_ADDR_READ);
      repeat ($urandom_range(0, 3)) send_op(OP_BYTE_TX_ACK);
      if ($urandom_range(0, 1) != 0) send_op(OP_STOP);
    end else if (kind < 85) begin
      // chain reset is usually followed by the activating change
      level = 1'($urandom_range(0, 1));
      send_event(OP_UPSTREAM, 8'($urandom_range(0, 255)), level);
      if (!level && $urandom_range(0, 9) != 0) send_op(OP_UPSTREAM);
    end else begin
      send_op(3'($urandom_range(0, 7)));
    end
  endtask

  // stimulus and verdict
  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_index_i      = CFG_MFR_CODE;
    cfg_data_i       = 8'h00;
    in_valid_i       = 1'b0;
    op_i             = OP_ADDR_WRITE;
    data_byte_i      = 8'h00;
    upstream_level_i = 1'b0;
    no_idle          = 1'b0;
    items_sent       = 0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    write_settings(8'hFF, 8'h00, 8'hA5);

    // directed: bus off, chain reset and activation, address set, reads, updates
    send_event(OP_ADDR_WRITE, 8'hFF, 1'b1);
    send_event(OP_UPSTREAM, 8'h00, 1'b1);
    send_event(OP_UPSTREAM, 8'hFF, 1'b0);
    send_event(OP_UPSTREAM, 8'h00, 1'b0);
    send_event(OP_BYTE_TX_ACK, 8'h00, 1'b0);
    send_event(OP_ADDR_WRITE, 8'h00, 1'b0);
    send_event(OP_BYTE_RX, 8'h00, 1'b0);
    send_event(OP_BYTE_RX, 8'h55, 1'b1);
    send_event(OP_STOP, 8'h00, 1'b0);
    send_event(OP_ADDR_READ, 8'h00, 1'b0);
    send_event(OP_BYTE_TX_ACK, 8'h00, 1'b0);
    send_event(OP_ADDR_WRITE, 8'h00, 1'b0);
    send_event(OP_BYTE_RX, 8'h03, 1'b0);
    send_event(OP_STOP, 8'h00, 1'b0);
    send_event(OP_ADDR_READ, 8'hFF, 1'b1);
    send_event(OP_ADDR_WRITE, 8'h00, 1'b0);
    send_event(OP_BYTE_RX, 8'hFF, 1'b0);
    send_event(OP_BYTE_RX, 8'hAA, 1'b0);
    send_event(OP_STOP, 8'h00, 1'b0);
    send_event(OP_STOP, 8'h00, 1'b0);
    send_event(OP_OTHER_LO, 8'hFF, 1'b1);
    send_event(OP_OTHER_HI, 8'h00, 1'b0);
    send_event(OP_UPSTREAM, 8'h00, 1'b1);

    // random phases, each under its own register setting
    for (int phase = 0; phase < PHASES; phase++) begin
      write_settings(pick_setting(), pick_setting(), pick_setting());
      no_idle = (phase == 2);
      while (items_sent < TARGET_ITEMS * (phase + 1) / PHASES) random_transaction();
    end

    in_valid_i = 1'b0;
    no_idle    = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### daisy_chain_i2c_register_slave_core.f
rtl/dcirs_pkg.sv
rtl/dcirs_store.sv
rtl/daisy_chain_i2c_register_slave_core.sv
tb/sv/dcirs_link_checker.sv
tb/sv/daisy_chain_i2c_register_slave_core_tb.sv
